@@ sv/text_console_cursor_scroll_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the text console cursor/scroll unit
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_UNIT_ASSERT_SVH

// Checked property, masked while reset is high
`define TCCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also active during reset
`define TCCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/tccs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared sizes, character codes, beat types and sequencer states of the
// text console cursor/scroll unit.
// ----------------------------------------------------------------------------
package tccs_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int KEEP_CELLS = (ROWS - 1) * COLUMNS;   // cells that move on scroll
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS + 2);       // row may overshoot by two
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int CWORK_W    = COL_W + 1;              // column scratch width
  localparam int CUR_W      = (ADDR_W > 12) ? ADDR_W : 12;

  // Field widths
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CIDX_W = 12;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  // Request modes
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } req_t;

  typedef struct packed {
    logic [CIDX_W-1:0] cursor_index;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_SCROLL,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ sv/tccs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/text_console_cursor_scroll_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit
// Text console: a cell RAM of ROWS x COLUMNS, a cursor, newline, tab and
// backspace handling and a one-line scroll.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req): a put beat writes char_code at the
//   cursor in the current color and moves the cursor; a read beat fetches one
//   cell. rsp channel (rsp_valid/rsp_stall/rsp): one beat per request with
//   the cursor index after the step, the read cell (0 for puts and for reads
//   past the screen) and the scroll flag.
//   cfg_wr_en/cfg_wr_data set the color; write only while the unit is idle.
// Timing:
//   A put passes through the EXEC and DONE states and its response is
//   registered on leaving DONE; the next request is taken only back in IDLE.
//   A read adds the RDATA state for the RAM read. A put that scrolls sweeps
//   the whole cell RAM through its single read and write port, one cell a
//   cycle, in the SCROLL state and then the DRAIN state.
// Reset:
//   After rst the unit clears the RAM to space/0x07, one cell a cycle, in
//   the CLEAR state with req_stall high. Config writes still land.
// Stall:
//   The response sits in an output register; one further request is taken
//   while it waits, then req_stall stays high until rsp_stall drops.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit
  import tccs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rsp_t                   rsp,
  input  wire logic              cfg_wr_en,
  input  wire logic [ATTR_W-1:0] cfg_wr_data
);

  state_t              state, state_next;
  logic [ADDR_W-1:0]   cnt, cnt_next;
  logic                p_valid, p_valid_next;
  logic [ADDR_W-1:0]   p_addr, p_addr_next;
  logic                p_blank, p_blank_next;
  logic [ROW_W-1:0]    cur_row, cur_row_next;
  logic [COL_W-1:0]    cur_col, cur_col_next;
  req_t                req_q;
  logic [CELL_W-1:0]   res_data, res_data_next;
  logic                res_scr, res_scr_next;
  logic [ATTR_W-1:0]   text_color;
  logic                rsp_valid_next;
  rsp_t                rsp_next;

  // RAM port signals
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  // Cursor scratch
  logic [CWORK_W-1:0]  c_work;
  logic [ROW_W-1:0]    r_work;
  logic [ADDR_W-1:0]   put_addr;
  logic [CUR_W-1:0]    cursor_full;
  logic                rd_in_range;
  logic                last_cell;

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_stall   = (state != ST_IDLE);
  assign put_addr    = ADDR_W'(ADDR_W'(cur_row) * ADDR_W'(COLUMNS)) + ADDR_W'(cur_col);
  assign cursor_full = CUR_W'(CUR_W'(cur_row) * CUR_W'(COLUMNS)) + CUR_W'(cur_col);
  assign rd_in_range = (32'(req_q.cell_index) < 32'(CELL_COUNT));
  assign last_cell   = (cnt == ADDR_W'(CELL_COUNT - 1));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control and cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      p_valid    <= 1'b0;
      cur_row    <= '0;
      cur_col    <= '0;
      text_color <= RESET_ATTR;
      rsp_valid  <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      p_valid   <= p_valid_next;
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_wr_en) begin
        text_color <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    p_addr   <= p_addr_next;
    p_blank  <= p_blank_next;
    res_data <= res_data_next;
    res_scr  <= res_scr_next;
    rsp      <= rsp_next;
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
  end

  // Sequencer: next state, RAM access, cursor update
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    p_valid_next   = 1'b0;
    p_addr_next    = cnt;
    p_blank_next   = 1'b0;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    res_data_next  = res_data;
    res_scr_next   = res_scr;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    ram_raddr      = '0;
    c_work         = '0;
    r_work         = '0;

    // Write side: scroll pipeline stage by default
    ram_we    = p_valid;
    ram_waddr = p_addr;
    ram_wdata = p_blank ? {text_color, CH_SPACE} : ram_rdata;

    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = {RESET_ATTR, CH_SPACE};
        cnt_next  = cnt + 1'b1;
        if (last_cell) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (req_q.mode == MODE_READ) begin
          ram_raddr    = ADDR_W'(req_q.cell_index);
          res_scr_next = 1'b0;
          state_next   = ST_RDATA;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = put_addr;
          ram_wdata = {text_color, req_q.char_code};

          // Advance with wrap
          c_work = CWORK_W'(cur_col) + 1'b1;
          r_work = cur_row;
          if (c_work >= CWORK_W'(COLUMNS)) begin
            c_work = '0;
            r_work = r_work + 1'b1;
          end

          // Control characters
          case (req_q.char_code)
            CH_NL: begin
              c_work = '0;
              r_work = r_work + 1'b1;
            end
            CH_TAB: begin
              c_work = ((c_work + CWORK_W'(7)) & ~CWORK_W'(7)) + 1'b1;
              if (c_work >= CWORK_W'(COLUMNS)) begin
                c_work = '0;
                r_work = r_work + 1'b1;
              end
            end
            CH_BS: begin
              c_work = (c_work >= CWORK_W'(2)) ? c_work - CWORK_W'(2) : '0;
            end
            default: begin
            end
          endcase

          res_data_next = '0;
          cur_col_next  = COL_W'(c_work);
          if (r_work >= ROW_W'(ROWS)) begin
            cur_row_next = ROW_W'(ROWS - 1);
            res_scr_next = 1'b1;
            cnt_next     = '0;
            state_next   = ST_SCROLL;
          end else begin
            cur_row_next = r_work;
            res_scr_next = 1'b0;
            state_next   = ST_DONE;
          end
        end
      end

      ST_RDATA: begin
        res_data_next = rd_in_range ? ram_rdata : '0;
        state_next    = ST_DONE;
      end

      // Sweep: read cnt+COLUMNS now, write it to cnt next cycle; last row blanked
      ST_SCROLL: begin
        if (32'(cnt) < 32'(KEEP_CELLS)) begin
          ram_raddr = cnt + ADDR_W'(COLUMNS);
        end
        p_valid_next = 1'b1;
        p_addr_next  = cnt;
        p_blank_next = (32'(cnt) >= 32'(KEEP_CELLS));
        cnt_next     = cnt + 1'b1;
        if (last_cell) begin
          cnt_next   = '0;
          state_next = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next        = 1'b1;
          rsp_next.cursor_index = cursor_full[CIDX_W-1:0];
          rsp_next.cell_data    = res_data;
          rsp_next.scrolled     = res_scr;
          state_next            = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/tccs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_checker
// Port-level checks of the text console cursor/scroll unit, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_unit_assert.svh"

module tccs_checker
  import tccs_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  // Stalled response beat holds
  `TCCS_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp)), "rsp beat changed under stall")

  // Cursor always on screen
  `TCCS_ASSERT(a_cursor_range, (rsp_valid |-> (32'(rsp.cursor_index) < 32'(CELL_COUNT))), "cursor off screen")

  // A scroll leaves the cursor on the last row
  `TCCS_ASSERT(a_scroll_row, (rsp_valid && rsp.scrolled |-> (CELL_COUNT > 4096) || (32'(rsp.cursor_index) >= 32'(KEEP_CELLS))), "scroll left cursor above last row")

  // One request at a time
  `TCCS_ASSERT(a_one_busy, (req_valid && !req_stall |=> req_stall), "request taken while busy")

  // Reset empties the output and holds off requests during the clear
  `TCCS_ASSERT_RST(a_reset, (rst |=> !rsp_valid && req_stall), "reset did not quiesce")

endmodule

bind text_console_cursor_scroll_unit tccs_checker u_tccs_checker (.*);
`default_nettype wire
